### sv/fifo_page_replacement_top_assert.svh
// assertion macros for the fifo page replacement block
`ifndef FIFO_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define FIFO_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define FPR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fpr_pkg.sv
// shared types, codes and constants of the fifo page replacement block
`default_nettype none

package fpr_pkg;

	localparam int PROCESS_COUNT_DEF   = 256;
	localparam int PAGE_COUNT_DEF      = 256;
	localparam int FRAME_COUNT_MAX_DEF = 256;

	localparam int FIELD_SPAN    = 256;
	localparam int ID_W          = 8;
	localparam int IN_W          = 16;
	localparam int OUT_W         = 96;
	localparam int TOTAL_W       = 32;
	localparam int CFG_INDEX_W   = 8;
	localparam int FRAME_COUNT_W = 9;
	localparam int CFG_DATA_W    = 9;

	localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 9'd256;

	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT    = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_UNLIMITED_MODE = 8'd1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_EVICT
	} state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} map_ctl_t;

	typedef struct packed {
		logic look;
		logic commit;
	} frame_op_t;

endpackage

`default_nettype wire

### sv/fpr_page_map.sv
// page map memory with its clearing pass after reset
`default_nettype none

module fpr_page_map #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 9
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  fpr_pkg::map_ctl_t       ctl,
	input  wire  [AW-1:0]           raddr,
	input  wire  [AW-1:0]           waddr,
	input  wire  [DW-1:0]           wdata,
	output logic [DW-1:0]           rdata,
	output logic                    busy
);
	import fpr_pkg::*;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// one write port: the sweep owns it until done
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (ctl.wr) begin
			mem[waddr] <= wdata;
		end
		if (ctl.rd) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

`default_nettype wire

### sv/fpr_frame_ctl.sv
// frame owner memory, replacement pointer and fill count
`default_nettype none

module fpr_frame_ctl #(
	parameter int FRAME_COUNT_MAX = 256,
	parameter int OWN_W           = 32,
	parameter int FRAME_W         = 8
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  fpr_pkg::frame_op_t                    op,
	input  wire  [fpr_pkg::FRAME_COUNT_W-1:0]     frame_count,
	input  wire  [OWN_W-1:0]                      owner_wdata,
	output logic [FRAME_W-1:0]                    frame,
	output logic                                  occupied,
	output logic [OWN_W-1:0]                      owner_rdata
);
	import fpr_pkg::*;

	localparam int CNT_W = $clog2(FRAME_COUNT_MAX + 1);
	localparam int CW    = (CNT_W > FRAME_COUNT_W) ? CNT_W : FRAME_COUNT_W;

	logic [OWN_W-1:0]   owner_mem [FRAME_COUNT_MAX];
	logic [OWN_W-1:0]   owner_rd_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic               occ_s1;
	logic [FRAME_W-1:0] ptr_q;
	logic [CNT_W-1:0]   fill_q;

	logic [CW-1:0]      fc_ext;
	logic [CW-1:0]      n_frames;
	logic [FRAME_W-1:0] f_pick;
	logic [FRAME_W-1:0] ptr_next;

	always_comb begin
		fc_ext = CW'(frame_count);
		if (fc_ext == '0) begin
			n_frames = CW'(1);
		end else if (fc_ext > CW'(FRAME_COUNT_MAX)) begin
			n_frames = CW'(FRAME_COUNT_MAX);
		end else begin
			n_frames = fc_ext;
		end
		// pointer left beyond a shrunk frame count falls back to frame zero
		f_pick   = (CW'(ptr_q) >= n_frames) ? '0 : ptr_q;
		ptr_next = ((CW'(frame_s1) + CW'(1)) >= n_frames) ? '0 : frame_s1 + FRAME_W'(1);
	end

	always_ff @(posedge clk) begin
		if (op.look) begin
			owner_rd_s1 <= owner_mem[f_pick];
			frame_s1    <= f_pick;
		end
		if (op.commit) begin
			owner_mem[frame_s1] <= owner_wdata;
		end
	end

	// frames fill strictly in order from zero, so occupancy is a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			occ_s1 <= 1'b0;
		end else begin
			if (op.look) begin
				occ_s1 <= (CNT_W'(f_pick) < fill_q);
			end
			if (op.commit) begin
				ptr_q <= ptr_next;
				if (CNT_W'(frame_s1) >= fill_q) begin
					fill_q <= CNT_W'(frame_s1) + CNT_W'(1);
				end
			end
		end
	end

	assign frame       = frame_s1;
	assign occupied    = occ_s1;
	assign owner_rdata = owner_rd_s1;

endmodule

`default_nettype wire

### sv/fifo_page_replacement_top.sv
// fifo page replacement top level: control sequencer, totals and stream ports
// an input beat is taken only in the idle state; its result beat is registered
// in the lookup state once the output slot is free; a miss that evicts adds an
// eviction state, set by the single write port of the page map (new mapping,
// then clearing the evicted mapping); reset: a clearing pass sweeps every page
// map entry, with s_tready low; configuration is taken throughout
`default_nettype none

`include "fifo_page_replacement_top_assert.svh"

module fifo_page_replacement_top #(
	parameter int PROCESS_COUNT   = fpr_pkg::PROCESS_COUNT_DEF,
	parameter int PAGE_COUNT      = fpr_pkg::PAGE_COUNT_DEF,
	parameter int FRAME_COUNT_MAX = fpr_pkg::FRAME_COUNT_MAX_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// process_id, virtual_page
	input  wire  [fpr_pkg::IN_W-1:0]           s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// hit, frame, evicted, evicted_process, evicted_page, hit_total, miss_total
	output logic [fpr_pkg::OUT_W-1:0]          m_tdata,
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [fpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [fpr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fpr_pkg::*;

	localparam int MAP_DEPTH = PROCESS_COUNT * PAGE_COUNT;
	localparam int MAP_AW    = $clog2(MAP_DEPTH);
	localparam int FRAME_W   = (FRAME_COUNT_MAX > 1) ? $clog2(FRAME_COUNT_MAX) : 1;
	localparam int MAP_DW    = FRAME_W + 1;
	localparam int OWN_W     = MAP_AW + 2 * ID_W;
	localparam int PAD_W     = OUT_W - (2 + 3 * ID_W + 2 * TOTAL_W);

	// configuration
	logic [FRAME_COUNT_W-1:0] frame_count_q;
	logic                     unlimited_q;

	// reduction of the raw ids into the parameter ranges
	logic [ID_W-1:0] proc_lut [FIELD_SPAN];
	logic [ID_W-1:0] page_lut [FIELD_SPAN];

	for (genvar g = 0; g < FIELD_SPAN; g++) begin : g_lut
		assign proc_lut[g] = ID_W'(g % PROCESS_COUNT);
		assign page_lut[g] = ID_W'(g % PAGE_COUNT);
	end

	logic [ID_W-1:0]   in_proc;
	logic [ID_W-1:0]   in_page;
	logic [MAP_AW-1:0] in_idx;

	assign in_proc = proc_lut[s_tdata[ID_W-1:0]];
	assign in_page = page_lut[s_tdata[2*ID_W-1:ID_W]];
	assign in_idx  = MAP_AW'(32'(in_proc) * PAGE_COUNT + 32'(in_page));

	state_t            state_q, state_d;
	logic [ID_W-1:0]   proc_s1, page_s1;
	logic [MAP_AW-1:0] idx_s1;
	logic [MAP_AW-1:0] ev_idx_q;

	map_ctl_t          map_ctl;
	logic [MAP_AW-1:0] map_waddr;
	logic [MAP_DW-1:0] map_wdata;
	logic [MAP_DW-1:0] map_rdata;
	logic              map_busy;

	frame_op_t         fop;
	logic [FRAME_W-1:0] frame_sel;
	logic              frame_occ;
	logic [OWN_W-1:0]  owner_rdata;

	// result registers
	logic               out_valid_q;
	logic               out_hit_q;
	logic [ID_W-1:0]    out_frame_q;
	logic               out_evicted_q;
	logic [ID_W-1:0]    out_ev_proc_q;
	logic [ID_W-1:0]    out_ev_page_q;
	logic [TOTAL_W-1:0] hits_q, misses_q;

	logic               slot_free;
	logic               load_out;
	logic               map_hit;
	logic [ID_W-1:0]    res_frame;
	logic               res_evict;
	logic [ID_W-1:0]    res_ev_proc;
	logic [ID_W-1:0]    res_ev_page;
	logic [TOTAL_W-1:0] hits_d, misses_d;

	fpr_page_map #(
		.DEPTH (MAP_DEPTH),
		.AW    (MAP_AW),
		.DW    (MAP_DW)
	) u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (map_ctl),
		.raddr (in_idx),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.rdata (map_rdata),
		.busy  (map_busy)
	);

	fpr_frame_ctl #(
		.FRAME_COUNT_MAX(FRAME_COUNT_MAX),
		.OWN_W          (OWN_W),
		.FRAME_W        (FRAME_W)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (fop),
		.frame_count(frame_count_q),
		.owner_wdata({idx_s1, proc_s1, page_s1}),
		.frame      (frame_sel),
		.occupied   (frame_occ),
		.owner_rdata(owner_rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RESET;
			unlimited_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_COUNT: begin
					frame_count_q <= cfg_data[FRAME_COUNT_W-1:0];
				end
				REG_UNLIMITED_MODE: begin
					unlimited_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// result of the lookup whose read data is now out of the page map
	always_comb begin
		map_hit   = map_rdata[MAP_DW-1];
		slot_free = !out_valid_q || m_tready;
		if (unlimited_q) begin
			res_frame = '0;
		end else if (map_hit) begin
			res_frame = ID_W'(map_rdata[FRAME_W-1:0]);
		end else begin
			res_frame = ID_W'(frame_sel);
		end
		res_evict   = !map_hit && !unlimited_q && frame_occ;
		res_ev_page = res_evict ? owner_rdata[ID_W-1:0] : '0;
		res_ev_proc = res_evict ? owner_rdata[2*ID_W-1:ID_W] : '0;
		hits_d      = (map_hit && (hits_q != '1)) ? hits_q + TOTAL_W'(1) : hits_q;
		misses_d    = (!map_hit && (misses_q != '1)) ? misses_q + TOTAL_W'(1) : misses_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		map_ctl   = '0;
		map_waddr = idx_s1;
		map_wdata = '0;
		fop       = '0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				if (!map_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					map_ctl.rd = 1'b1;
					fop.look   = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
					if (!map_hit) begin
						map_ctl.wr = 1'b1;
						if (unlimited_q) begin
							map_wdata = {1'b1, FRAME_W'(0)};
						end else begin
							map_wdata  = {1'b1, frame_sel};
							fop.commit = 1'b1;
							if (frame_occ) begin
								state_d = ST_EVICT;
							end
						end
					end
				end
			end
			ST_EVICT: begin
				// drop the displaced owner's mapping
				map_ctl.wr = 1'b1;
				map_waddr  = ev_idx_q;
				map_wdata  = '0;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			proc_s1 <= in_proc;
			page_s1 <= in_page;
			idx_s1  <= in_idx;
		end
		if (load_out) begin
			out_hit_q     <= map_hit;
			out_frame_q   <= res_frame;
			out_evicted_q <= res_evict;
			out_ev_proc_q <= res_ev_proc;
			out_ev_page_q <= res_ev_page;
			ev_idx_q      <= owner_rdata[OWN_W-1:2*ID_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hits_q      <= '0;
			misses_q    <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
				hits_q      <= hits_d;
				misses_q    <= misses_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {PAD_W'(0), misses_q, hits_q, out_ev_page_q, out_ev_proc_q,
		out_evicted_q, out_frame_q, out_hit_q};

	`FPR_ASSERT_NOW(a_no_beat_while_clearing, s_tvalid && s_tready, !map_busy,
		"input beat taken during page map clearing pass")
	`FPR_ASSERT_NOW(a_evict_after_lookup, state_q == ST_EVICT, $past(state_q) == ST_LOOKUP,
		"eviction write-back not preceded by a lookup")
	`FPR_ASSERT_NXT(a_totals_monotone, 1'b1,
		(hits_q >= $past(hits_q)) && (misses_q >= $past(misses_q)),
		"hit or miss total went backwards")

endmodule

`default_nettype wire
